@@ hdl/pmd_pkg.sv @@
package pmd_pkg;

  localparam logic [1:0] MODE_GENERIC = 2'd0;
  localparam logic [1:0] MODE_WHEEL   = 2'd1;
  localparam logic [1:0] MODE_FIVE    = 2'd2;

  localparam logic [1:0] REG_MOUSE_MODE = 2'd0;
  localparam logic [1:0] REG_X_LIMIT    = 2'd1;
  localparam logic [1:0] REG_Y_LIMIT    = 2'd2;

  localparam logic [15:0] LIMIT_RESET = 16'hffff;

  localparam int unsigned SYNC_BIT = 3;

  localparam logic [8:0] DELTA_POS_SAT = 9'h0ff;
  localparam logic [8:0] DELTA_NEG_SAT = 9'h101;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } pkt_t;

endpackage

@@ hdl/pmd_front.sv @@
module pmd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_data_byte,
  input  logic [1:0]     mouse_mode,
  input  logic           q_full,
  output logic           q_push,
  output pmd_pkg::pkt_t  q_pkt
);

  logic [1:0] byte_index_r;
  logic [1:0] byte_index_nxt;
  logic [7:0] pkt_r [0:2];
  logic       four;
  logic [1:0] last;
  logic       accept;
  logic       drop;
  logic       complete;

  always_comb begin
    unique case (mouse_mode) inside
      pmd_pkg::MODE_WHEEL, pmd_pkg::MODE_FIVE: four = 1'b1;
      default:                                 four = 1'b0;
    endcase
  end

  assign last     = four ? 2'd3 : 2'd2;
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign drop     = (byte_index_r == 2'd0) && !in_data_byte[pmd_pkg::SYNC_BIT];
  assign complete = !drop && (byte_index_r >= last);
  assign q_push   = accept && complete;

  always_comb begin
    q_pkt.mode = mouse_mode;
    q_pkt.b0   = pkt_r[0];
    q_pkt.b1   = pkt_r[1];
    q_pkt.b2   = (byte_index_r == 2'd2) ? in_data_byte : pkt_r[2];
    q_pkt.b3   = four ? in_data_byte : 8'd0;
  end

  always_comb begin
    byte_index_nxt = byte_index_r;
    if (accept && !drop) begin
      byte_index_nxt = complete ? 2'd0 : byte_index_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= 2'd0;
    end else begin
      byte_index_r <= byte_index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !drop && !complete && byte_index_r != 2'd3) begin
      pkt_r[byte_index_r] <= in_data_byte;
    end
  end

endmodule

@@ hdl/pmd_queue.sv @@
module pmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pmd_pkg::pkt_t  push_pkt,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output pmd_pkg::pkt_t  head_pkt
);

  pmd_pkg::pkt_t                  mem_r [0:pmd_pkg::QUEUE_DEPTH-1];
  logic [pmd_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [pmd_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [pmd_pkg::QCNT_W-1:0]     count_r;
  logic [pmd_pkg::QCNT_W-1:0]     count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count_r == pmd_pkg::QCNT_W'(pmd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_pkt   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

@@ hdl/pmd_back.sv @@
module pmd_back #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  pmd_pkg::pkt_t       head_pkt,
  output logic                pop,
  input  logic [15:0]         x_limit,
  input  logic [15:0]         y_limit,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_abs_x,
  output logic [15:0]         out_abs_y,
  output logic signed [8:0]   out_delta_x,
  output logic signed [8:0]   out_delta_y,
  output logic [4:0]          out_buttons,
  output logic signed [7:0]   out_wheel
);

  localparam int W  = POSITION_WIDTH;
  localparam int SW = W + 2;
  localparam int CW = (W > 16) ? W : 16;

  logic                 out_valid_r;
  logic [15:0]          abs_x_r;
  logic [15:0]          abs_y_r;
  logic signed [8:0]    delta_x_r;
  logic signed [8:0]    delta_y_r;
  logic [4:0]           buttons_r;
  logic signed [7:0]    wheel_r;
  logic [W-1:0]         pos_x_r;
  logic [W-1:0]         pos_y_r;
  logic [W-1:0]         pos_x_nxt;
  logic [W-1:0]         pos_y_nxt;
  logic signed [8:0]    dx;
  logic signed [8:0]    dy;
  logic [4:0]           buttons;
  logic signed [7:0]    wheel;
  logic [W-1:0]         lim_x;
  logic [W-1:0]         lim_y;

  function automatic logic signed [8:0] make_delta(input logic [7:0] mag,
                                                   input logic sign,
                                                   input logic ovf);
    logic signed [8:0] d;
    if (ovf) begin
      d = sign ? pmd_pkg::DELTA_NEG_SAT : pmd_pkg::DELTA_POS_SAT;
    end else begin
      d = {sign, mag};
    end
    return d;
  endfunction

  function automatic logic [W-1:0] cap_limit(input logic [15:0] limit);
    logic [CW-1:0] lim_e;
    logic [CW-1:0] max_e;
    lim_e = CW'(limit);
    max_e = CW'({W{1'b1}});
    if (lim_e > max_e) begin
      lim_e = max_e;
    end
    return lim_e[W-1:0];
  endfunction

  function automatic logic [W-1:0] move_axis(input logic [W-1:0] pos,
                                             input logic signed [8:0] delta,
                                             input logic [W-1:0] lim);
    logic signed [SW-1:0] v;
    logic [W-1:0]         r;
    v = $signed({2'b00, pos}) + $signed({{(SW-9){delta[8]}}, delta});
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, lim})) begin
      r = lim;
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  assign pop   = head_valid && (!out_valid_r || !out_stall);
  assign dx    = make_delta(head_pkt.b1, head_pkt.b0[4], head_pkt.b0[6]);
  assign dy    = make_delta(head_pkt.b2, head_pkt.b0[5], head_pkt.b0[7]);
  assign lim_x = cap_limit(x_limit);
  assign lim_y = cap_limit(y_limit);
  assign pos_x_nxt = move_axis(pos_x_r, dx, lim_x);
  assign pos_y_nxt = move_axis(pos_y_r, dy, lim_y);

  always_comb begin
    buttons = {2'b00, head_pkt.b0[2:0]};
    wheel   = '0;
    unique case (head_pkt.mode)
      pmd_pkg::MODE_WHEEL: begin
        wheel = head_pkt.b3;
      end
      pmd_pkg::MODE_FIVE: begin
        wheel   = {{4{head_pkt.b3[3]}}, head_pkt.b3[3:0]};
        buttons = {head_pkt.b3[5], head_pkt.b3[4], head_pkt.b0[2:0]};
      end
      default: begin
        wheel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      abs_x_r   <= 16'(pos_x_nxt);
      abs_y_r   <= 16'(pos_y_nxt);
      delta_x_r <= dx;
      delta_y_r <= dy;
      buttons_r <= buttons;
      wheel_r   <= wheel;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_abs_x   = abs_x_r;
  assign out_abs_y   = abs_y_r;
  assign out_delta_x = delta_x_r;
  assign out_delta_y = delta_y_r;
  assign out_buttons = buttons_r;
  assign out_wheel   = wheel_r;

endmodule

@@ hdl/ps2_mouse_packet_decoder.sv @@
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_data_byte[7:0]
// out_     output     out_valid/out_stall abs_x, abs_y, delta_x, delta_y, buttons, wheel
// cfg_     input      cfg_valid/cfg_ready cfg_index[1:0], cfg_data[15:0]
//
// One byte per cycle while in_stall is low. A completed packet passes through a
// two-entry packet queue into the output register.
// Synchronous active-low reset clears the byte counter, queue and positions;
// limits reset to 65535, mode to generic.
// in_stall rises only while the queue is full; out_stall holds the output register.
module ps2_mouse_packet_decoder #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_abs_x,
  output logic [15:0]        out_abs_y,
  output logic signed [8:0]  out_delta_x,
  output logic signed [8:0]  out_delta_y,
  output logic [4:0]         out_buttons,
  output logic signed [7:0]  out_wheel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [1:0]     mouse_mode_r;
  logic [15:0]    x_limit_r;
  logic [15:0]    y_limit_r;
  logic           q_push;
  logic           q_full;
  pmd_pkg::pkt_t  push_pkt;
  pmd_pkg::pkt_t  head_pkt;
  logic           head_valid;
  logic           pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mouse_mode_r <= pmd_pkg::MODE_GENERIC;
      x_limit_r    <= pmd_pkg::LIMIT_RESET;
      y_limit_r    <= pmd_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmd_pkg::REG_MOUSE_MODE: mouse_mode_r <= cfg_data[1:0];
        pmd_pkg::REG_X_LIMIT:    x_limit_r    <= cfg_data;
        pmd_pkg::REG_Y_LIMIT:    y_limit_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pmd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .mouse_mode   (mouse_mode_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_pkt        (push_pkt)
  );

  pmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_pkt   (push_pkt),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_pkt   (head_pkt)
  );

  pmd_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_pkt    (head_pkt),
    .pop         (pop),
    .x_limit     (x_limit_r),
    .y_limit     (y_limit_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_abs_x   (out_abs_x),
    .out_abs_y   (out_abs_y),
    .out_delta_x (out_delta_x),
    .out_delta_y (out_delta_y),
    .out_buttons (out_buttons),
    .out_wheel   (out_wheel)
  );

endmodule

@@ tb/mouse_event_checker.sv @@
module mouse_event_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [15:0]       out_abs_x,
  input  logic [15:0]       out_abs_y,
  input  logic signed [8:0] out_delta_x,
  input  logic signed [8:0] out_delta_y,
  input  logic [4:0]        out_buttons,
  input  logic signed [7:0] out_wheel,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int unsigned       mismatches,
  output int unsigned       events_pending,
  output int unsigned       events_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]       ax;
    logic [15:0]       ay;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [4:0]        btn;
    logic signed [7:0] whl;
  } mouse_event_t;

  mouse_event_t event_queue[$];

  logic [1:0]  mode;
  logic [15:0] x_limit;
  logic [15:0] y_limit;
  logic [1:0]  byte_idx;
  logic [7:0]  held [3];
  logic [15:0] pos_x;
  logic [15:0] pos_y;

  int unsigned errs;
  int unsigned checked;

  function automatic logic signed [8:0] axis_delta(input logic [7:0] mag, input logic sgn,
                                                   input logic ovf);
    if (ovf) return sgn ? -9'sd255 : 9'sd255;
    return {sgn, mag};
  endfunction

  function automatic logic [15:0] clamp_axis(input logic [15:0] pos,
                                             input logic signed [8:0] d,
                                             input logic [15:0] lim);
    int v;
    v = int'(pos) + int'(d);
    if (v < 0) v = 0;
    if (v > int'(lim)) v = int'(lim);
    return v[15:0];
  endfunction

  function automatic void decode_byte(input logic [7:0] d);
    logic         four;
    logic [1:0]   last_idx;
    logic [7:0]   b0;
    logic [7:0]   b2;
    logic [7:0]   b3;
    mouse_event_t ev;
    four = (mode == pmd_pkg::MODE_WHEEL) || (mode == pmd_pkg::MODE_FIVE);
    last_idx = four ? 2'd3 : 2'd2;
    if (byte_idx == 2'd0 && !d[pmd_pkg::SYNC_BIT]) return;
    if (byte_idx < last_idx) begin
      held[byte_idx] = d;
      byte_idx = byte_idx + 2'd1;
      return;
    end
    b0 = held[0];
    b2 = (byte_idx == 2'd2) ? d : held[2];
    b3 = (four && byte_idx == 2'd3) ? d : 8'h00;
    byte_idx = 2'd0;
    ev.dx = axis_delta(held[1], b0[4], b0[6]);
    ev.dy = axis_delta(b2, b0[5], b0[7]);
    pos_x = clamp_axis(pos_x, ev.dx, x_limit);
    pos_y = clamp_axis(pos_y, ev.dy, y_limit);
    ev.ax = pos_x;
    ev.ay = pos_y;
    ev.btn = {2'b00, b0[2:0]};
    ev.whl = 8'sd0;
    case (mode)
      pmd_pkg::MODE_WHEEL: ev.whl = b3;
      pmd_pkg::MODE_FIVE: begin
        ev.whl = {{4{b3[3]}}, b3[3:0]};
        ev.btn[4:3] = {b3[5], b3[4]};
      end
      default: ;
    endcase
    event_queue.push_back(ev);
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    mouse_event_t ev;
    if (!rst_n) begin
      mode     = pmd_pkg::MODE_GENERIC;
      x_limit  = pmd_pkg::LIMIT_RESET;
      y_limit  = pmd_pkg::LIMIT_RESET;
      byte_idx = 2'd0;
      held     = '{default: 8'h00};
      pos_x    = 16'd0;
      pos_y    = 16'd0;
      event_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (event_queue.size() == 0) begin
          $error("event with no packet outstanding: abs %0d,%0d", out_abs_x, out_abs_y);
          errs++;
        end else begin
          ev = event_queue.pop_front();
          compare_field("abs_x", int'(ev.ax), int'(out_abs_x));
          compare_field("abs_y", int'(ev.ay), int'(out_abs_y));
          compare_field("delta_x", int'(ev.dx), int'(out_delta_x));
          compare_field("delta_y", int'(ev.dy), int'(out_delta_y));
          compare_field("buttons", int'(ev.btn), int'(out_buttons));
          compare_field("wheel", int'(ev.whl), int'(out_wheel));
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pmd_pkg::REG_MOUSE_MODE: mode = cfg_data[1:0];
          pmd_pkg::REG_X_LIMIT:    x_limit = cfg_data;
          pmd_pkg::REG_Y_LIMIT:    y_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(in_data_byte);
    end
    mismatches     <= errs;
    events_pending <= event_queue.size();
    events_checked <= checked;
  end

endmodule

@@ tb/ps2_mouse_packet_decoder_tb.sv @@
module ps2_mouse_packet_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE  = 2'd3;
  localparam int unsigned IDLE_PCT  = 28;
  localparam int unsigned PHASE_BYTES = 210;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_abs_x;
  logic [15:0] out_abs_y;
  logic signed [8:0] out_delta_x;
  logic signed [8:0] out_delta_y;
  logic [4:0]  out_buttons;
  logic signed [7:0] out_wheel;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  logic        calm = 1'b0;
  logic [1:0]  cur_mode = pmd_pkg::MODE_GENERIC;
  logic [15:0] cur_xl = pmd_pkg::LIMIT_RESET;
  logic [15:0] cur_yl = pmd_pkg::LIMIT_RESET;
  int unsigned bytes_sent;
  int unsigned settings_used;
  int unsigned mismatches;
  int unsigned events_pending;
  int unsigned events_checked;

  ps2_mouse_packet_decoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_abs_x    (out_abs_x),
    .out_abs_y    (out_abs_y),
    .out_delta_x  (out_delta_x),
    .out_delta_y  (out_delta_y),
    .out_buttons  (out_buttons),
    .out_wheel    (out_wheel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mouse_event_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_abs_x      (out_abs_x),
    .out_abs_y      (out_abs_y),
    .out_delta_x    (out_delta_x),
    .out_delta_y    (out_delta_y),
    .out_buttons    (out_buttons),
    .out_wheel      (out_wheel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .events_pending (events_pending),
    .events_checked (events_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 4000 && events_pending != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_regs(input logic [1:0] m, input logic [15:0] xl, input logic [15:0] yl,
                           input bit spare);
    if (spare) write_reg(REG_SPARE, 16'($urandom));
    write_reg(pmd_pkg::REG_MOUSE_MODE, {14'($urandom), m});
    write_reg(pmd_pkg::REG_X_LIMIT, xl);
    write_reg(pmd_pkg::REG_Y_LIMIT, yl);
    cfg_valid <= 1'b0;
    cur_mode = m;
    cur_xl = xl;
    cur_yl = yl;
    settings_used++;
  endtask

  function automatic logic lean(input int drift);
    if (drift > 0) return $urandom_range(99) < 15;
    if (drift < 0) return $urandom_range(99) < 85;
    return 1'($urandom);
  endfunction

  function automatic int unsigned packet_len();
    return (cur_mode == pmd_pkg::MODE_WHEEL || cur_mode == pmd_pkg::MODE_FIVE) ? 4 : 3;
  endfunction

  task automatic send_packet(input int drift);
    logic [7:0] head;
    head[7]   = $urandom_range(99) < 12;
    head[6]   = $urandom_range(99) < 12;
    head[5]   = lean(drift);
    head[4]   = lean(drift);
    head[3]   = 1'b1;
    head[2:0] = 3'($urandom);
    send_byte(head);
    repeat (packet_len() - 1) send_byte(8'($urandom));
  endtask

  initial begin : stimulus
    int          drift;
    int unsigned stop_at;
    int unsigned pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hcf); send_byte(8'hff); send_byte(8'hff);
    send_byte(8'h38); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hf8); send_byte(8'h12); send_byte(8'h34);
    settle();
    load_regs(pmd_pkg::MODE_WHEEL, cur_xl, cur_yl, 1'b0);
    send_byte(8'h08); send_byte(8'h7f); send_byte(8'h80); send_byte(8'h80);
    settle();
    load_regs(pmd_pkg::MODE_FIVE, cur_xl, cur_yl, 1'b0);
    send_byte(8'h0f); send_byte(8'h01); send_byte(8'hff); send_byte(8'h3f);
    // switch modes with a packet half collected
    send_byte(8'h09); send_byte(8'h10); send_byte(8'h20);
    settle();
    load_regs(pmd_pkg::MODE_GENERIC, cur_xl, cur_yl, 1'b0);
    send_byte(8'h55);
    send_byte(8'h0a); send_byte(8'h05);
    settle();
    load_regs(pmd_pkg::MODE_WHEEL, cur_xl, cur_yl, 1'b0);
    send_byte(8'h06); send_byte(8'h81);

    for (int p = 0; p < 8; p++) begin
      settle();
      calm = (p == 3);
      case (p)
        0: begin
          load_regs(pmd_pkg::MODE_GENERIC, pmd_pkg::LIMIT_RESET, pmd_pkg::LIMIT_RESET, 1'b0);
          drift = 1;
        end
        1: begin load_regs(pmd_pkg::MODE_WHEEL, 16'd0, 16'd0, 1'b0); drift = 1; end
        2: begin load_regs(pmd_pkg::MODE_FIVE, 16'd300, pmd_pkg::LIMIT_RESET, 1'b0); drift = 1; end
        3: begin load_regs(MODE_SPARE, pmd_pkg::LIMIT_RESET, 16'd200, 1'b0); drift = -1; end
        4: begin load_regs(pmd_pkg::MODE_WHEEL, 16'd1000, 16'd1000, 1'b0); drift = 1; end
        5: begin load_regs(pmd_pkg::MODE_FIVE, 16'd150, 16'd150, 1'b0); drift = -1; end
        6: begin
          load_regs(pmd_pkg::MODE_GENERIC, 16'($urandom), 16'($urandom), 1'b1);
          drift = 0;
        end
        default: begin
          load_regs(2'($urandom), 16'($urandom_range(2000)), 16'($urandom_range(2000)), 1'b0);
          drift = 0;
        end
      endcase
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 82) begin
          send_packet(drift);
        end else if (pick < 92) begin
          // drop the tail of a packet
          send_byte(8'($urandom) | 8'h08);
          repeat ($urandom_range(packet_len() - 2)) send_byte(8'($urandom));
        end else begin
          send_byte(8'($urandom));
        end
      end
    end
    calm = 1'b0;

    settle();
    if (events_pending != 0) $error("%0d events never arrived", events_pending);
    $display("covered %0d input bytes under %0d register settings, all four mode codes",
             bytes_sent, settings_used);
    $display("%0d events checked, %0d mismatches", events_checked, mismatches);
    if (mismatches == 0 && events_pending == 0) begin
      $display("ps2_mouse_packet_decoder regression: pass");
    end else begin
      $display("ps2_mouse_packet_decoder regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("ps2_mouse_packet_decoder regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hdl/pmd_pkg.sv
hdl/pmd_front.sv
hdl/pmd_queue.sv
hdl/pmd_back.sv
hdl/ps2_mouse_packet_decoder.sv
tb/mouse_event_checker.sv
tb/ps2_mouse_packet_decoder_tb.sv
